### rtl/gcrsde_pkg.sv
// Shared types, constants and the 4-to-5 GCR group encoder for the sector data encoder.
// No dependencies.
package gcrsde_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned GroupBytes = 5;
   localparam int unsigned CountW     = $clog2(GroupBytes);

   localparam logic [7:0]  BLOCK_ID    = 8'h07;
   localparam logic [7:0]  SECTOR_LAST = 8'hff;
   localparam logic [23:0] GROUP_START = {BLOCK_ID, 16'h0000};

   localparam logic [CountW-1:0] LAST_BYTE = CountW'(GroupBytes - 1);

   localparam logic [4:0] NIB_CODE [16] = '{
      5'h0a, 5'h0b, 5'h12, 5'h13, 5'h0e, 5'h0f, 5'h16, 5'h17,
      5'h09, 5'h19, 5'h1a, 5'h1b, 5'h0d, 5'h1d, 5'h1e, 5'h15
   };

   // one group of four block bytes, first byte in bits 31:24
   typedef struct packed {
      logic [31:0] group_bytes;
      logic        final_group;
   } group_entry_type;

   typedef struct packed {
      logic            push;
      group_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            valid;
      group_entry_type entry;
   } queue_head_type;

   // eight nibbles, high nibble first, each to a 5-bit code
   function automatic logic [39:0] encode_group(input logic [31:0] grp);
      logic [39:0] bits;
      bits = '0;
      for (int i = 0; i < 8; i++) begin
         bits[39 - 5*i -: 5] = NIB_CODE[grp[31 - 4*i -: 4]];
      end
      return bits;
   endfunction

endpackage

### rtl/gcrsde_front.sv
// Front end: takes data bytes, keeps position and checksum, assembles groups of four.
// Depends on gcrsde_pkg.
module gcrsde_front
   import gcrsde_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           queue_full,
   output queue_push_type push_out
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  xor_ff, xor_in;
   logic [23:0] pend_ff, pend_in;
   logic        take;

   assign req_tready = !queue_full;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      pos_in   = pos_ff;
      xor_in   = xor_ff;
      pend_in  = pend_ff;
      push_out = '0;
      if (take) begin
         xor_in = xor_ff ^ req_tdata;
         if (pos_ff == SECTOR_LAST) begin
            // last data byte, checksum, two zero pads
            push_out.push                    = 1'b1;
            push_out.entry.group_bytes       = {req_tdata, xor_in, 16'h0000};
            push_out.entry.final_group       = 1'b1;
            pos_in  = '0;
            xor_in  = '0;
            pend_in = GROUP_START;
         end else begin
            pos_in = pos_ff + 8'd1;
            case (pos_ff[1:0])
               2'd0: pend_in[15:8]  = req_tdata;
               2'd1: pend_in[7:0]   = req_tdata;
               2'd2: begin
                  push_out.push              = 1'b1;
                  push_out.entry.group_bytes = {pend_ff, req_tdata};
                  push_out.entry.final_group = 1'b0;
                  pend_in = '0;
               end
               2'd3: pend_in[23:16] = req_tdata;
               default: pend_in = pend_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         xor_ff  <= '0;
         pend_ff <= GROUP_START;
      end else begin
         pos_ff  <= pos_in;
         xor_ff  <= xor_in;
         pend_ff <= pend_in;
      end
   end

endmodule

### rtl/gcrsde_queue.sv
// Short group queue between front and back end.
// Depends on gcrsde_pkg.
module gcrsde_queue
   import gcrsde_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push_in,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   group_entry_type         mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]      count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   assign do_push = push_in.push && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/gcrsde_back.sv
// Back end: encodes a queued group to 40 bits and shifts it out one byte per cycle
// while rsp_tready is high. Depends on gcrsde_pkg.
module gcrsde_back
   import gcrsde_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,
   output logic           rsp_tlast,
   output logic           rsp_tuser
);

   logic              busy_ff, busy_in;
   logic [39:0]       bits_ff, bits_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic              final_ff, final_in;
   logic              sent, at_last;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = bits_ff[39:32];
   assign at_last    = (cnt_ff == LAST_BYTE);
   assign rsp_tlast  = at_last;
   assign rsp_tuser  = final_ff && at_last;
   assign sent       = busy_ff && rsp_tready;

   // load the next group with no bubble after the fifth byte
   assign pop = head.valid && (!busy_ff || (sent && at_last));

   always_comb begin
      busy_in  = busy_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      final_in = final_ff;
      if (pop) begin
         busy_in  = 1'b1;
         bits_in  = encode_group(head.entry.group_bytes);
         cnt_in   = '0;
         final_in = head.entry.final_group;
      end else if (sent) begin
         bits_in = {bits_ff[31:0], 8'h00};
         cnt_in  = cnt_ff + 1'b1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      final_ff <= final_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/gcr_sector_data_encoder.sv
// GCR sector data block encoder. The input item that completes a group writes it into the
// group queue; the back end then loads it into its shift register. One input item per cycle
// until the 4-entry group queue fills; the output side sends one byte per cycle while
// rsp_tready is high, 5 per group, so the back-end shifter sets the sustained rate.
// Reset (synchronous): start of sector, checksum zero, queue and output empty.
module gcr_sector_data_encoder
   import gcrsde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] gcr_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] end_of_sector
);

   queue_push_type push;
   queue_head_type head;
   logic           queue_full;
   logic           pop;

   gcrsde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_out   (push)
   );

   gcrsde_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .pop     (pop),
      .head    (head)
   );

   gcrsde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
